// ----- rtl/core/cdmp_pkg.sv -----
`timescale 1ns / 1ps

package cdmp_pkg;

    // dial geometry
    localparam int DIAL_STEPS    = 491520;
    localparam int MINS_PER_HOUR = 60;
    localparam int HALF_DAY_MINS = 720;
    localparam int NEAR_STEPS    = 1000;

    // field widths
    localparam int HOUR_W = 4;
    localparam int MIN_W  = 6;
    localparam int POS_W  = 19;

    // minutes, hour*60 + minute, 60..779
    localparam int TIME_W = 10;

    // target = time*DIAL_Q + (time*DIAL_R)/720
    localparam int DIAL_Q = DIAL_STEPS / HALF_DAY_MINS;
    localparam int DIAL_R = DIAL_STEPS % HALF_DAY_MINS;
    localparam int A_W    = TIME_W + $clog2(DIAL_Q + 1);
    localparam int N_W    = TIME_W + 10;

    // reciprocal of 720, good for N_W bit dividends with one correction
    localparam int REC_K  = N_W;
    localparam int REC_M  = (1 << REC_K) / HALF_DAY_MINS;
    localparam int REC_MW = $clog2(REC_M + 1);
    localparam int REC_PW = N_W + REC_MW;

    localparam int TGT_W  = $clog2(DIAL_STEPS + 1);
    localparam int RAW_W  = TGT_W + 1;
    localparam int BASE_W = (TGT_W > POS_W) ? TGT_W : POS_W;
    localparam int S_W    = BASE_W + 2;

    // plan codes
    localparam logic [1:0] PLAN_SINGLE   = 2'd0;
    localparam logic [1:0] PLAN_ROLL     = 2'd1;
    localparam logic [1:0] PLAN_CROSS_LO = 2'd2;
    localparam logic [1:0] PLAN_CROSS_HI = 2'd3;

    // command kinds
    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    localparam int PLAN_DEPTH = 4;
    localparam int PLAN_PTR_W = $clog2(PLAN_DEPTH);

    typedef struct packed {
        logic [1:0]       code;
        logic             skip;
        logic [POS_W-1:0] tgt;
    } cdmp_plan_t;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] value;
        logic             last;
    } cdmp_cmd_t;

endpackage

// ----- rtl/core/clock_dial_move_planner.sv -----
`timescale 1ns / 1ps
// path: a request passes the seven front stages, the plan FIFO and the result buffer before its first command shows
// throughput: one request per cycle into the seven-stage planning pipeline while full
// is low; the command sequencer issues one command per cycle while its result buffer
// has room, and a request's plan holds one to three commands
// reset: asynchronous, clears all valid flags and queue counts; no clearing pass
module clock_dial_move_planner
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [cdmp_pkg::HOUR_W-1:0] hour,
    input  logic [cdmp_pkg::MIN_W-1:0]  minute,
    input  logic [cdmp_pkg::POS_W-1:0]  current_position,
    output logic                        empty,
    input  logic                        pop,
    output logic                        kind,
    output logic [cdmp_pkg::POS_W-1:0]  value,
    output logic                        last
);

    logic                 fr_valid, fr_full;
    cdmp_pkg::cdmp_plan_t fr_plan;
    logic                 q_valid, q_pop;
    cdmp_pkg::cdmp_plan_t q_plan;

    cdmp_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .hour             (hour),
        .minute           (minute),
        .current_position (current_position),
        .plan_valid       (fr_valid),
        .plan             (fr_plan),
        .plan_full        (fr_full)
    );

    cdmp_plan_fifo u_plan_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_data  (fr_plan),
        .full     (fr_full),
        .rd_valid (q_valid),
        .rd_data  (q_plan),
        .rd_pop   (q_pop)
    );

    cdmp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (q_valid),
        .plan       (q_plan),
        .plan_pop   (q_pop),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .value      (value),
        .last       (last)
    );

endmodule

// ----- rtl/core/cdmp_front.sv -----
`timescale 1ns / 1ps

module cdmp_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [cdmp_pkg::HOUR_W-1:0] hour,
    input  logic [cdmp_pkg::MIN_W-1:0]  minute,
    input  logic [cdmp_pkg::POS_W-1:0]  current_position,
    output logic                        plan_valid,
    output cdmp_pkg::cdmp_plan_t        plan,
    input  logic                        plan_full
);

    localparam int POS_W  = cdmp_pkg::POS_W;
    localparam int TIME_W = cdmp_pkg::TIME_W;
    localparam int A_W    = cdmp_pkg::A_W;
    localparam int N_W    = cdmp_pkg::N_W;
    localparam int TGT_W  = cdmp_pkg::TGT_W;
    localparam int RAW_W  = cdmp_pkg::RAW_W;
    localparam int S_W    = cdmp_pkg::S_W;
    localparam int REC_PW = cdmp_pkg::REC_PW;
    localparam int HOUR_W = cdmp_pkg::HOUR_W;
    localparam int MIN_W  = cdmp_pkg::MIN_W;

    localparam logic signed [S_W-1:0] DIAL_S    = S_W'(cdmp_pkg::DIAL_STEPS);
    localparam logic signed [S_W-1:0] NEAR_LO_S = S_W'(cdmp_pkg::NEAR_STEPS);
    localparam logic signed [S_W-1:0] NEAR_HI_S =
        S_W'(cdmp_pkg::DIAL_STEPS - cdmp_pkg::NEAR_STEPS);
    localparam logic signed [S_W-1:0] HALF_S    = S_W'(cdmp_pkg::DIAL_STEPS / 2);

    // stage valids and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;
    logic time_ok;

    // payload
    logic [TIME_W-1:0] m1_reg;
    logic [POS_W-1:0]  cur1_reg, cur2_reg, cur3_reg, cur4_reg, cur5_reg;
    logic [A_W-1:0]    a2_reg, a3_reg;
    logic [N_W-1:0]    n2_reg, n3_reg;
    logic [TIME_W-1:0] q3_reg;
    logic [RAW_W-1:0]  raw4_reg;
    logic [TGT_W-1:0]  tgt5_reg;

    logic signed [S_W-1:0] fwd6_reg, bwd6_reg;
    logic [POS_W-1:0]      tgt6_reg;
    logic gt6_reg, lt6_reg, edge12_6_reg, roll6_reg, cur0_6_reg, curd6_reg, lohalf6_reg;

    logic [TIME_W-1:0]     m1_next;
    logic [REC_PW-1:0]     rec_prod;
    logic [TIME_W-1:0]     q3_next;
    logic [N_W-1:0]        q720, rem4;
    logic [RAW_W-1:0]      raw4_next;
    logic [TGT_W-1:0]      tgt5_next;
    logic signed [S_W-1:0] ts, cs, fwd6_next, bwd6_next;
    logic                  tgt12, cur12, near12;
    logic                  fwd_dir, crosses;
    cdmp_pkg::cdmp_plan_t  plan_next;

    assign ld7 = !v7_reg || !plan_full;
    assign ld6 = !v6_reg || ld7;
    assign ld5 = !v5_reg || ld6;
    assign ld4 = !v4_reg || ld5;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign full = !ld1;

    assign time_ok = (hour >= HOUR_W'(1)) && (hour <= HOUR_W'(12))
                  && (minute <= MIN_W'(59));

    assign m1_next = TIME_W'(hour) * TIME_W'(cdmp_pkg::MINS_PER_HOUR) + TIME_W'(minute);

    // reciprocal estimate, low by at most one
    assign rec_prod = REC_PW'(n2_reg) * REC_PW'(cdmp_pkg::REC_M);
    assign q3_next  = rec_prod[cdmp_pkg::REC_K +: TIME_W];

    assign q720 = N_W'(q3_reg) * N_W'(cdmp_pkg::HALF_DAY_MINS);
    assign rem4 = n3_reg - q720;
    assign raw4_next = RAW_W'(a3_reg) + RAW_W'(q3_reg)
                     + RAW_W'(rem4 >= N_W'(cdmp_pkg::HALF_DAY_MINS));

    assign tgt5_next = (raw4_reg >= RAW_W'(cdmp_pkg::DIAL_STEPS))
                     ? TGT_W'(raw4_reg - RAW_W'(cdmp_pkg::DIAL_STEPS))
                     : TGT_W'(raw4_reg);

    assign ts = S_W'(tgt5_reg);
    assign cs = S_W'(cur5_reg);
    assign fwd6_next = (ts >= cs) ? (ts - cs) : (DIAL_S - cs + ts);
    assign bwd6_next = (cs >= ts) ? (cs - ts) : (cs + DIAL_S - ts);
    assign tgt12  = (ts == '0) || (ts == DIAL_S);
    assign cur12  = (cs == '0) || (cs == DIAL_S);
    assign near12 = (cs > NEAR_HI_S) || (cs < NEAR_LO_S);

    // direction and plan selection
    assign fwd_dir = fwd6_reg <= bwd6_reg;
    assign crosses = (gt6_reg && !fwd_dir) || (lt6_reg && fwd_dir);

    always_comb
    begin
        plan_next.tgt  = tgt6_reg;
        plan_next.code = cdmp_pkg::PLAN_SINGLE;
        plan_next.skip = 1'b0;
        priority if (edge12_6_reg)
        begin
            if (roll6_reg)
            begin
                plan_next.code = cdmp_pkg::PLAN_ROLL;
                plan_next.skip = curd6_reg;
            end
        end
        else if (crosses)
        begin
            if (lohalf6_reg)
            begin
                plan_next.code = cdmp_pkg::PLAN_CROSS_LO;
                plan_next.skip = cur0_6_reg;
            end
            else
            begin
                plan_next.code = cdmp_pkg::PLAN_CROSS_HI;
                plan_next.skip = curd6_reg;
            end
        end
        else
        begin
            plan_next.code = cdmp_pkg::PLAN_SINGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            // an invalid time is dropped on transfer
            if (ld1) v1_reg <= push && time_ok;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ld5) v5_reg <= v4_reg;
            if (ld6) v6_reg <= v5_reg;
            if (ld7) v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            m1_reg   <= m1_next;
            cur1_reg <= current_position;
        end
        if (ld2)
        begin
            a2_reg   <= A_W'(m1_reg) * A_W'(cdmp_pkg::DIAL_Q);
            n2_reg   <= N_W'(m1_reg) * N_W'(cdmp_pkg::DIAL_R);
            cur2_reg <= cur1_reg;
        end
        if (ld3)
        begin
            a3_reg   <= a2_reg;
            n3_reg   <= n2_reg;
            q3_reg   <= q3_next;
            cur3_reg <= cur2_reg;
        end
        if (ld4)
        begin
            raw4_reg <= raw4_next;
            cur4_reg <= cur3_reg;
        end
        if (ld5)
        begin
            tgt5_reg <= tgt5_next;
            cur5_reg <= cur4_reg;
        end
        if (ld6)
        begin
            fwd6_reg     <= fwd6_next;
            bwd6_reg     <= bwd6_next;
            tgt6_reg     <= POS_W'(tgt5_reg);
            gt6_reg      <= ts > cs;
            lt6_reg      <= ts < cs;
            edge12_6_reg <= (tgt12 || cur12) && near12;
            roll6_reg    <= (ts == '0) && (cs > NEAR_HI_S);
            cur0_6_reg   <= cs == '0;
            curd6_reg    <= cs == DIAL_S;
            lohalf6_reg  <= cs < HALF_S;
        end
        if (ld7)
        begin
            plan <= plan_next;
        end
    end

    assign plan_valid = v7_reg;

endmodule

// ----- rtl/core/cdmp_plan_fifo.sv -----
`timescale 1ns / 1ps

module cdmp_plan_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    input  cdmp_pkg::cdmp_plan_t wr_data,
    output logic                 full,
    output logic                 rd_valid,
    output cdmp_pkg::cdmp_plan_t rd_data,
    input  logic                 rd_pop
);

    localparam int PTR_W = cdmp_pkg::PLAN_PTR_W;
    localparam int CNT_W = PTR_W + 1;

    cdmp_pkg::cdmp_plan_t mem [cdmp_pkg::PLAN_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full     = cnt_reg == CNT_W'(cdmp_pkg::PLAN_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && !full;
    assign do_rd    = rd_pop && rd_valid;
    assign cnt_next = cnt_reg + CNT_W'(do_wr) - CNT_W'(do_rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr) wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_rd) rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/cdmp_back.sv -----
`timescale 1ns / 1ps

module cdmp_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       plan_valid,
    input  cdmp_pkg::cdmp_plan_t       plan,
    output logic                       plan_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic                       kind,
    output logic [cdmp_pkg::POS_W-1:0] value,
    output logic                       last
);

    localparam int POS_W = cdmp_pkg::POS_W;
    localparam logic [POS_W-1:0] VAL_DIAL = POS_W'(cdmp_pkg::DIAL_STEPS);
    localparam logic [POS_W-1:0] VAL_ZERO = '0;

    logic [1:0] off_reg, off_next, start, slot;
    cdmp_pkg::cdmp_cmd_t cmd;
    logic emit;

    // two-entry result buffer
    cdmp_pkg::cdmp_cmd_t ob_mem [2];
    logic       ob_wr_reg, ob_rd_reg;
    logic [1:0] ob_cnt_reg, ob_cnt_next;
    logic       ob_pop;

    assign start = (plan.code == cdmp_pkg::PLAN_SINGLE) ? 2'd2 : {1'b0, plan.skip};
    assign slot  = start + off_reg;

    always_comb
    begin
        cmd.kind  = cdmp_pkg::KIND_MOVE;
        cmd.value = plan.tgt;
        cmd.last  = 1'b1;
        unique case (plan.code)
            cdmp_pkg::PLAN_ROLL:
            begin
                if (slot == 2'd0)
                begin
                    cmd.value = VAL_DIAL;
                    cmd.last  = 1'b0;
                end
                else
                begin
                    cmd.kind  = cdmp_pkg::KIND_SET;
                    cmd.value = VAL_ZERO;
                end
            end
            cdmp_pkg::PLAN_CROSS_LO:
            begin
                if (slot == 2'd0)
                begin
                    cmd.value = VAL_ZERO;
                    cmd.last  = 1'b0;
                end
                else if (slot == 2'd1)
                begin
                    cmd.kind  = cdmp_pkg::KIND_SET;
                    cmd.value = VAL_DIAL;
                    cmd.last  = 1'b0;
                end
            end
            cdmp_pkg::PLAN_CROSS_HI:
            begin
                if (slot == 2'd0)
                begin
                    cmd.value = VAL_DIAL;
                    cmd.last  = 1'b0;
                end
                else if (slot == 2'd1)
                begin
                    cmd.kind  = cdmp_pkg::KIND_SET;
                    cmd.value = VAL_ZERO;
                    cmd.last  = 1'b0;
                end
            end
            default:
            begin
                cmd.last = 1'b1;
            end
        endcase
    end

    assign emit     = plan_valid && (ob_cnt_reg != 2'd2);
    assign plan_pop = emit && cmd.last;
    assign off_next = plan_pop ? 2'd0 : (emit ? off_reg + 2'd1 : off_reg);

    assign empty       = ob_cnt_reg == 2'd0;
    assign ob_pop      = pop && !empty;
    assign ob_cnt_next = ob_cnt_reg + 2'(emit) - 2'(ob_pop);

    assign kind  = ob_mem[ob_rd_reg].kind;
    assign value = ob_mem[ob_rd_reg].value;
    assign last  = ob_mem[ob_rd_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg    <= 2'd0;
            ob_wr_reg  <= 1'b0;
            ob_rd_reg  <= 1'b0;
            ob_cnt_reg <= 2'd0;
        end
        else
        begin
            off_reg    <= off_next;
            ob_cnt_reg <= ob_cnt_next;
            if (emit)   ob_wr_reg <= !ob_wr_reg;
            if (ob_pop) ob_rd_reg <= !ob_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ob_mem[ob_wr_reg] <= cmd;
        end
    end

endmodule

// ----- rtl/core/cdmp_checker.sv -----
`timescale 1ns / 1ps

module cdmp_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic                       kind,
    input logic [cdmp_pkg::POS_W-1:0] value,
    input logic                       last
);

    // nothing held over reset
    a_reset_clear: assert property (@(posedge clk) !rst_n |=> (empty && !full))
        else $error("queue flags not clear in reset");

    // a closing set command is always the rebase to zero
    a_last_set_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind && last) |-> (value == '0))
        else $error("final set command not at zero");

    // a rebase mid-request is followed by the move to target
    a_set_then_move: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && kind && !last) ##1 !empty |-> (!kind && last))
        else $error("rebase not followed by final move");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(value) && $stable(last)))
        else $error("waiting result changed");

endmodule

bind clock_dial_move_planner cdmp_checker u_cdmp_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .kind  (kind),
    .value (value),
    .last  (last)
);
